// ===== hdl/hrlp_pkg.sv =====
// Package for the hex record line parser: types, codes and constants.
`timescale 1ns / 1ps
`default_nettype none
package hrlp_pkg;

  localparam logic [7:0] ColonChar  = 8'h3A;
  localparam int unsigned PosW      = 10;
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};
  localparam logic [PosW-1:0] HdrLastPos = 10'd8;
  localparam logic [PosW-1:0] FixedTerm  = 10'd11;
  localparam logic [8:0] HeaderBytes     = 9'd4;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_COLON    = 3'd1,
    ERR_LENGTH   = 3'd2,
    ERR_CHECKSUM = 3'd3,
    ERR_HEX      = 3'd4,
    ERR_HEX_LATE = 3'd5
  } err_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_COLON = 3'd1,
    ST_LENGTH   = 3'd2,
    ST_CHECKSUM = 3'd3,
    ST_BAD_HEX  = 3'd4
  } status_e;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  // Classified word passed from front to back.
  typedef struct packed {
    logic       eor;
    logic       is_colon;
    logic       hex_ok;
    logic [3:0] nibble;
  } item_t;

endpackage
`default_nettype wire

// ===== hdl/hrlp_front.sv =====
// Front end: accepts characters and classifies them into nibble, hex-valid, colon and end flags.
`timescale 1ns / 1ps
`default_nettype none
module hrlp_front import hrlp_pkg::*; (
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       end_of_record_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output item_t           item_o
);

  logic [3:0] nib;
  logic       ok;

  always_comb begin
    nib = 4'd0;
    ok  = 1'b1;
    case (char_code_i) inside
      [8'h30:8'h39]: nib = char_code_i[3:0];
      [8'h41:8'h46],
      [8'h61:8'h66]: nib = char_code_i[3:0] + 4'd9;
      default:       ok  = 1'b0;
    endcase
  end

  assign in_ready_o       = !q_full_i;
  assign push_o           = in_valid_i && !q_full_i;
  assign item_o.eor       = end_of_record_i;
  assign item_o.is_colon  = (char_code_i == ColonChar);
  assign item_o.hex_ok    = ok;
  assign item_o.nibble    = nib;

endmodule
`default_nettype wire

// ===== hdl/hrlp_fifo.sv =====
// Two-entry queue between the front end and the parser back end.
`timescale 1ns / 1ps
`default_nettype none
module hrlp_fifo import hrlp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      wdata_i,
  input  wire logic  pop_i,
  output item_t      rdata_o,
  output logic       full_o,
  output logic       valid_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);

endmodule
`default_nettype wire

// ===== hdl/hrlp_back.sv =====
// Back end: record field tracking, checksum, error ranking and the output register.
`timescale 1ns / 1ps
`default_nettype none
module hrlp_back import hrlp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  item_t            q_item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic [7:0]       data_byte_o,
  output logic [15:0]      byte_address_o,
  output logic [7:0]       record_type_o,
  output logic [7:0]       byte_count_o,
  output logic [2:0]       status_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [3:0]      hi_q, hi_d;
  logic [7:0]      cnt_q, cnt_d;
  logic [15:0]     addr_q, addr_d;
  logic [7:0]      type_q, type_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      off_q, off_d;
  err_e            err_q, err_d;

  logic            ov_q, ov_d;
  logic            kind_q, kind_d;
  logic [7:0]      data_q, data_d;
  logic [15:0]     oaddr_q, oaddr_d;
  logic [7:0]      otype_q, otype_d;
  logic [7:0]      ocnt_q, ocnt_d;
  logic [2:0]      ost_q, ost_d;

  logic [PosW-1:0] term_pos;
  logic [PosW-1:0] pm1;
  logic [8:0]      idx;
  logic [7:0]      b;
  logic            emit;
  status_e         st;

  assign term_pos = FixedTerm + {1'b0, cnt_q, 1'b0};
  assign pm1      = pos_q - 10'd1;
  assign idx      = pm1[PosW-1:1];
  assign b        = {hi_q, q_item_i.nibble};
  assign pop_o    = q_valid_i && (!ov_q || out_ready_i);

  always_comb begin
    pos_d  = pos_q;
    hi_d   = hi_q;
    cnt_d  = cnt_q;
    addr_d = addr_q;
    type_d = type_q;
    sum_d  = sum_q;
    off_d  = off_q;
    err_d  = err_q;
    emit   = 1'b0;
    st     = ST_OK;
    kind_d  = kind_q;
    data_d  = data_q;
    oaddr_d = oaddr_q;
    otype_d = otype_q;
    ocnt_d  = ocnt_q;
    ost_d   = ost_q;

    if (pop_o) begin
      if (q_item_i.eor) begin
        if (pos_q == '0 || err_q == ERR_COLON)             st = ST_NO_COLON;
        else if (err_q == ERR_HEX)                         st = ST_BAD_HEX;
        else if (err_q == ERR_LENGTH || pos_q != term_pos) st = ST_LENGTH;
        else if (err_q == ERR_HEX_LATE)                    st = ST_BAD_HEX;
        else if (sum_q != 8'd0)                            st = ST_CHECKSUM;
        else                                               st = ST_OK;
        emit    = 1'b1;
        kind_d  = KIND_STATUS;
        data_d  = 8'd0;
        oaddr_d = addr_q;
        otype_d = type_q;
        ocnt_d  = cnt_q;
        ost_d   = st;
        pos_d   = '0;
        hi_d    = 4'd0;
        cnt_d   = 8'd0;
        addr_d  = 16'd0;
        type_d  = 8'd0;
        sum_d   = 8'd0;
        off_d   = 8'd0;
        err_d   = ERR_NONE;
      end else begin
        if (pos_q == '0) begin
          if (!q_item_i.is_colon) err_d = ERR_COLON;
        end else if (err_q == ERR_COLON) begin
          err_d = ERR_COLON;
        end else if (pos_q >= term_pos) begin
          if (err_q == ERR_NONE || err_q == ERR_HEX_LATE) err_d = ERR_LENGTH;
        end else begin
          if (!q_item_i.hex_ok && err_q == ERR_NONE) begin
            err_d = (pos_q <= HdrLastPos) ? ERR_HEX : ERR_HEX_LATE;
          end
          if (pos_q[0]) begin
            hi_d = q_item_i.nibble;
          end else begin
            sum_d = sum_q + b;
            case (idx)
              9'd0:    cnt_d = b;
              9'd1:    addr_d = {b, addr_q[7:0]};
              9'd2:    addr_d = {addr_q[15:8], b};
              9'd3:    type_d = b;
              default: begin
                if (idx < HeaderBytes + {1'b0, cnt_q}) begin
                  if (err_d == ERR_NONE) begin
                    emit    = 1'b1;
                    kind_d  = KIND_DATA;
                    data_d  = b;
                    oaddr_d = addr_q + {8'd0, off_q};
                    otype_d = type_q;
                    ocnt_d  = cnt_q;
                    ost_d   = ST_OK;
                  end
                  off_d = off_q + 8'd1;
                end
              end
            endcase
          end
        end
        if (pos_q != PosMax) pos_d = pos_q + 10'd1;
      end
    end

    if (emit)             ov_d = 1'b1;
    else if (out_ready_i) ov_d = 1'b0;
    else                  ov_d = ov_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hi_q   <= 4'd0;
      cnt_q  <= 8'd0;
      addr_q <= 16'd0;
      type_q <= 8'd0;
      sum_q  <= 8'd0;
      off_q  <= 8'd0;
      err_q  <= ERR_NONE;
      ov_q   <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      hi_q   <= hi_d;
      cnt_q  <= cnt_d;
      addr_q <= addr_d;
      type_q <= type_d;
      sum_q  <= sum_d;
      off_q  <= off_d;
      err_q  <= err_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    data_q  <= data_d;
    oaddr_q <= oaddr_d;
    otype_q <= otype_d;
    ocnt_q  <= ocnt_d;
    ost_q   <= ost_d;
  end

  assign out_valid_o    = ov_q;
  assign kind_o         = kind_q;
  assign data_byte_o    = data_q;
  assign byte_address_o = oaddr_q;
  assign record_type_o  = otype_q;
  assign byte_count_o   = ocnt_q;
  assign status_o       = ost_q;

endmodule
`default_nettype wire

// ===== hdl/hex_record_line_parser.sv =====
// Top level of the hex record line parser: front end, queue and back end.
// An accepted word is written into the queue, and its result is then registered in the
// output register, from which the receiver takes it.
// Throughput: one character per cycle while the output is taken; the two-entry queue and
// the output register let input and output stall independently.
// Reset (rst_ni low, asynchronous) empties the queue and output and sets the parser to
// await a colon with all record fields cleared.
`timescale 1ns / 1ps
`default_nettype none
module hex_record_line_parser import hrlp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        end_of_record_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic [7:0]       data_byte_o,
  output logic [15:0]      byte_address_o,
  output logic [7:0]       record_type_o,
  output logic [7:0]       byte_count_o,
  output logic [2:0]       status_o
);

  item_t push_item;
  item_t pop_item;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_valid;

  hrlp_front u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_code_i     (char_code_i),
    .end_of_record_i (end_of_record_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .item_o          (push_item)
  );

  hrlp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_item),
    .pop_i   (pop),
    .rdata_o (pop_item),
    .full_o  (q_full),
    .valid_o (q_valid)
  );

  hrlp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (pop_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .byte_address_o (byte_address_o),
    .record_type_o  (record_type_o),
    .byte_count_o   (byte_count_o),
    .status_o       (status_o)
  );

endmodule
`default_nettype wire

// ===== hdl/hrlp_checker.sv =====
// Port-level checks for the hex record line parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module hrlp_checker import hrlp_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        kind_o,
  input wire logic [7:0]  data_byte_o,
  input wire logic [15:0] byte_address_o,
  input wire logic [2:0]  status_o
);

  // Held result word keeps its payload while stalled.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_byte_o)
      && $stable(byte_address_o) && $stable(status_o))
    else $error("result changed while stalled");

  a_data_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DATA |-> status_o == ST_OK)
    else $error("data word with non-zero status");

  a_status_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_STATUS |-> data_byte_o == 8'd0)
    else $error("status word with non-zero data");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_NO_COLON
      || status_o == ST_LENGTH || status_o == ST_CHECKSUM || status_o == ST_BAD_HEX)
    else $error("undefined status code");

endmodule

bind hex_record_line_parser hrlp_checker u_chk (.*);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the hex record line parser, predicting each result word.
module testbench;
  import hrlp_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned MaxReported = 10;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [15:0] addr;
    logic [7:0]  rtype;
    logic [7:0]  count;
    status_e     status;
  } result_t;

  typedef enum int unsigned {
    FLT_COLON    = 0,
    FLT_HEX_HDR  = 1,
    FLT_HEX_DATA = 2,
    FLT_SUM      = 3,
    FLT_SHORT    = 4,
    FLT_LONG     = 5,
    FLT_NOISE    = 6
  } fault_e;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_code_i     = 8'h00;
  logic        end_of_record_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic        kind_o;
  logic [7:0]  data_byte_o;
  logic [15:0] byte_address_o;
  logic [7:0]  record_type_o;
  logic [7:0]  byte_count_o;
  logic [2:0]  status_o;

  hex_record_line_parser u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_code_i     (char_code_i),
    .end_of_record_i (end_of_record_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .byte_address_o  (byte_address_o),
    .record_type_o   (record_type_o),
    .byte_count_o    (byte_count_o),
    .status_o        (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Parser state as predicted
  logic [PosW-1:0] rec_pos    = '0;
  logic [3:0]      rec_hi     = '0;
  logic [7:0]      rec_count  = '0;
  logic [15:0]     rec_addr   = '0;
  logic [7:0]      rec_type   = '0;
  logic [7:0]      rec_sum    = '0;
  logic [7:0]      rec_offset = '0;
  err_e            rec_err    = ERR_NONE;

  result_t     expected_q[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles    = 0;
  int unsigned words_sent     = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;

  function automatic logic [4:0] decode_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    return 5'b0;
  endfunction

  task automatic clear_record_state();
    rec_pos    = '0;
    rec_hi     = '0;
    rec_count  = '0;
    rec_addr   = '0;
    rec_type   = '0;
    rec_sum    = '0;
    rec_offset = '0;
    rec_err    = ERR_NONE;
  endtask

  task automatic parse_char(input logic [7:0] c, input logic eor);
    int unsigned term;
    int unsigned idx;
    logic [4:0]  dec;
    logic [7:0]  b;
    result_t     r;
    term = int'(FixedTerm) + 2 * int'(rec_count);
    if (eor) begin
      r.kind  = KIND_STATUS;
      r.data  = 8'h00;
      r.addr  = rec_addr;
      r.rtype = rec_type;
      r.count = rec_count;
      if (rec_pos == 0 || rec_err == ERR_COLON) r.status = ST_NO_COLON;
      else if (rec_err == ERR_HEX) r.status = ST_BAD_HEX;
      else if (rec_err == ERR_LENGTH || int'(rec_pos) != term) r.status = ST_LENGTH;
      else if (rec_err == ERR_HEX_LATE) r.status = ST_BAD_HEX;
      else if (rec_sum != 8'h00) r.status = ST_CHECKSUM;
      else r.status = ST_OK;
      expected_q = {expected_q, r};
      clear_record_state();
    end else begin
      if (rec_pos == 0) begin
        if (c != ColonChar) rec_err = ERR_COLON;
      end else if (rec_err != ERR_COLON) begin
        if (int'(rec_pos) >= term) begin
          if (rec_err == ERR_NONE || rec_err == ERR_HEX_LATE) rec_err = ERR_LENGTH;
        end else begin
          dec = decode_digit(c);
          if (!dec[4] && rec_err == ERR_NONE) begin
            if (rec_pos <= HdrLastPos) rec_err = ERR_HEX;
            else rec_err = ERR_HEX_LATE;
          end
          if (rec_pos[0]) begin
            rec_hi = dec[3:0];
          end else begin
            b = {rec_hi, dec[3:0]};
            idx = (int'(rec_pos) - 1) / 2;
            rec_sum = rec_sum + b;
            if (idx == 0) rec_count = b;
            else if (idx == 1) rec_addr[15:8] = b;
            else if (idx == 2) rec_addr[7:0] = b;
            else if (idx == 3) rec_type = b;
            else if (idx < int'(HeaderBytes) + int'(rec_count)) begin
              if (rec_err == ERR_NONE) begin
                r.kind   = KIND_DATA;
                r.data   = b;
                r.addr   = rec_addr + {8'h00, rec_offset};
                r.rtype  = rec_type;
                r.count  = rec_count;
                r.status = ST_OK;
                expected_q = {expected_q, r};
              end
              rec_offset = rec_offset + 8'd1;
            end
          end
        end
      end
      if (rec_pos != PosMax) rec_pos = rec_pos + 1'b1;
    end
  endtask

  task automatic send_word(input logic [7:0] c, input logic eor);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    char_code_i     <= c;
    end_of_record_i <= eor;
    do @(posedge clk_i); while (!in_ready_o);
    parse_char(c, eor);
    words_sent++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + n;
    if ($urandom_range(1) != 0) return "a" + n - 8'd10;
    return "A" + n - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [4:0] d;
    do begin
      c = 8'($urandom_range(255));
      d = decode_digit(c);
    end while (d[4]);
    return c;
  endfunction

  task automatic send_record(input logic [7:0] cnt, input logic [15:0] addr,
                             input logic [7:0] rtype, input logic [6:0] faults);
    logic [7:0]  bytes[$];
    logic [7:0]  line[$];
    logic [7:0]  sum;
    logic [7:0]  c;
    logic [4:0]  d;
    int unsigned k;
    bytes = {bytes, cnt};
    bytes = {bytes, addr[15:8]};
    bytes = {bytes, addr[7:0]};
    bytes = {bytes, rtype};
    repeat (cnt) bytes = {bytes, 8'($urandom_range(255))};
    sum = 8'h00;
    foreach (bytes[i]) sum = sum + bytes[i];
    bytes = {bytes, 8'(~sum + 8'd1)};
    line = {line, ColonChar};
    foreach (bytes[i]) begin
      line = {line, hex_char(bytes[i][7:4])};
      line = {line, hex_char(bytes[i][3:0])};
    end
    if (faults[FLT_COLON]) begin
      do c = 8'($urandom_range(255)); while (c == ColonChar);
      line[0] = c;
    end
    if (faults[FLT_HEX_HDR]) line[$urandom_range(8, 1)] = non_hex_char();
    if (faults[FLT_HEX_DATA]) line[$urandom_range(line.size() - 1, 9)] = non_hex_char();
    if (faults[FLT_SUM]) begin
      k = line.size() - 1;
      d = decode_digit(line[k]);
      line[k] = hex_char(d[3:0] ^ 4'($urandom_range(15, 1)));
    end
    if (faults[FLT_SHORT]) repeat ($urandom_range(line.size(), 1)) void'(line.pop_back());
    if (faults[FLT_LONG]) repeat ($urandom_range(6, 1)) line = {line, 8'($urandom_range(255))};
    if (faults[FLT_NOISE]) begin
      line.delete();
      repeat ($urandom_range(16)) line = {line, 8'($urandom_range(255))};
    end
    foreach (line[i]) send_word(line[i], 1'b0);
    send_word(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_random_record();
    int unsigned pick;
    logic [7:0]  cnt;
    logic [7:0]  rtype;
    logic [6:0]  faults;
    pick = $urandom_range(99);
    if (pick < 70) cnt = 8'($urandom_range(8));
    else if (pick < 98) cnt = 8'($urandom_range(40, 9));
    else cnt = 8'($urandom_range(255, 41));
    if ($urandom_range(3) != 0) rtype = 8'($urandom_range(5));
    else rtype = 8'($urandom_range(255));
    faults = '0;
    if ($urandom_range(99) < 25) begin
      do faults = 7'($urandom) & 7'($urandom); while (faults == '0);
    end
    send_record(cnt, 16'($urandom_range(65535)), rtype, faults);
  endtask

  task automatic wait_drained();
    int unsigned n;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    n = 0;
    while (expected_q.size() != 0 && n < 20000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Receiver: random stalls, or a forced hold-off
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic note_mismatch(input bit unexpected, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= MaxReported) begin
      if (unexpected)
        $display("unexpected word: kind %0d byte %h addr %h type %h count %h status %0d",
                 got.kind, got.data, got.addr, got.rtype, got.count, got.status);
      else
        $display("mismatch: exp kind %0d byte %h addr %h type %h count %h status %0d / got kind %0d byte %h addr %h type %h count %h status %0d",
                 want.kind, want.data, want.addr, want.rtype, want.count, want.status,
                 got.kind, got.data, got.addr, got.rtype, got.count, got.status);
    end
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind   = kind_e'(kind_o);
      got.data   = data_byte_o;
      got.addr   = byte_address_o;
      got.rtype  = record_type_o;
      got.count  = byte_count_o;
      got.status = status_e'(status_o);
      if (expected_q.size() == 0) begin
        note_mismatch(1'b1, got, got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) note_mismatch(1'b0, want, got);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("hex_record_line_parser verification failed");
    $finish;
  end

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_record(8'h00, 16'h0000, 8'h00, '0);
    send_record(8'h00, 16'h0000, 8'h01, '0);
    send_record(8'h10, 16'hFFF8, 8'hFF, '0);
    send_record(8'h03, 16'hFFFE, 8'h00, '0);
    send_record(8'h02, 16'h1234, 8'h00, 7'b1 << FLT_COLON);
    send_record(8'h02, 16'h1234, 8'h00, 7'b1 << FLT_HEX_HDR);
    send_record(8'h04, 16'h8000, 8'h00, 7'b1 << FLT_HEX_DATA);
    send_record(8'h02, 16'h00A5, 8'h02, 7'b1 << FLT_SUM);
    send_record(8'h02, 16'h5A00, 8'h04, 7'b1 << FLT_SHORT);
    send_record(8'h02, 16'h0100, 8'h00, 7'b1 << FLT_LONG);
    send_record(8'h01, 16'h0000, 8'h00, 7'b1 << FLT_NOISE);
    send_record(8'h02, 16'h4321, 8'h00, (7'b1 << FLT_HEX_HDR) | (7'b1 << FLT_LONG));
    send_record(8'h02, 16'h4321, 8'h00, (7'b1 << FLT_HEX_DATA) | (7'b1 << FLT_LONG));
    send_record(8'h02, 16'h4321, 8'h00, (7'b1 << FLT_HEX_DATA) | (7'b1 << FLT_SUM));
    // two empty records: terminators only
    send_word(8'h0A, 1'b1);
    send_word(8'h0D, 1'b1);
  endtask

  task automatic test_output_hold_off();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    hold_cycles = 300;
    repeat (4) send_record(8'h08, 16'($urandom_range(65535)), 8'h00, '0);
  endtask

  task automatic test_sender_pause();
    send_idle_pct  = 6;
    recv_stall_pct = 6;
    send_record(8'h05, 16'h2000, 8'h00, '0);
    wait_drained();
    send_record(8'h05, 16'h2005, 8'h00, '0);
    send_record(8'h00, 16'h0000, 8'h01, '0);
  endtask

  task automatic run_random_phase(input int unsigned idle, input int unsigned stall,
                                  input int unsigned budget);
    int unsigned start;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    start = words_sent;
    while (words_sent - start < budget) send_random_record();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_output_hold_off();
    test_sender_pause();
    run_random_phase(0, 0, 165);
    run_random_phase(73, 0, 165);
    run_random_phase(0, 73, 165);
    run_random_phase(6, 6, 165);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("hex_record_line_parser verification clean");
    end else begin
      $display("hex_record_line_parser verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/hrlp_pkg.sv
hdl/hrlp_front.sv
hdl/hrlp_fifo.sv
hdl/hrlp_back.sv
hdl/hex_record_line_parser.sv
hdl/hrlp_checker.sv
tb/sv/testbench.sv
